/* hw/rtl/b64c_pkg.sv */
// Base64 codec package: job word passed from front to back, alphabet mapping functions.
// No dependencies; used by every module of the codec by scoped names.
package b64c_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='

    // result step codes within one job
    localparam logic [1:0] DEC_STEP_BYTE = 2'd0;
    localparam logic [1:0] DEC_STEP_END  = 2'd1;
    localparam logic [1:0] ENC_STEP_LAST = 2'd3;

    // one unit of back-end work: an encode group or a decode output set
    typedef struct packed {
        logic        enc;       // 1: encode group, 0: decode
        logic [23:0] data;      // encode: 24-bit group; decode: byte in [7:0]
        logic [2:0]  nchar;     // encode: characters before padding (2..4)
        logic        has_byte;  // decode: a decoded byte is present
        logic        has_end;   // message ends with this job
    } job_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } char_val_t;

    function automatic logic [7:0] char_of(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = 8'(8'h41 + {2'b00, v});
        else if (v < 6'd52)
            c = 8'(8'h61 + {2'b00, v} - 8'd26);
        else if (v < 6'd62)
            c = 8'(8'h30 + {2'b00, v} - 8'd52);
        else if (v == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

    function automatic char_val_t value_of(input logic [7:0] c);
        char_val_t r;
        r.ok  = 1'b1;
        r.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A)
            r.val = 6'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A)
            r.val = 6'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39)
            r.val = 6'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B)
            r.val = 6'd62;
        else if (c == 8'h2F)
            r.val = 6'd63;
        else
            r.ok = 1'b0;
        return r;
    endfunction

endpackage

/* hw/rtl/b64c_front.sv */
// Codec front end: takes input words and config writes, keeps message state, builds jobs.
// Depends on b64c_pkg.
module b64c_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               codec_mode,
    input  logic               q_full,
    output logic               push,
    output b64c_pkg::job_t     push_job
);

    logic        mode_reg,    mode_next;
    logic [15:0] held_reg,    held_next;
    logic [1:0]  group_reg,   group_next;
    logic [5:0]  acc_reg,     acc_next;     // at most six pending bits between words
    logic [2:0]  cnt_reg,     cnt_next;     // pending bit count: 0, 2, 4 or 6
    logic        stopped_reg, stopped_next;

    logic                  accept;
    logic [1:0]            n;
    b64c_pkg::char_val_t   dv;
    logic [11:0]           acc12;
    logic [3:0]            cnt_sum;
    logic [3:0]            cnt_after;
    logic                  dec_has;
    logic [7:0]            dec_byte;

    // a cfg write takes the cycle; the input word is held off while it is offered
    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full && !cfg_valid;
    assign accept    = in_valid && in_ready;

    assign n         = group_reg + 2'd1;
    assign dv        = b64c_pkg::value_of(in_byte);
    assign acc12     = {acc_reg, dv.val};
    assign cnt_sum   = {1'b0, cnt_reg} + 4'd6;
    assign dec_has   = cnt_sum >= 4'd8;
    assign cnt_after = dec_has ? cnt_sum - 4'd8 : cnt_sum;
    assign dec_byte  = 8'(acc12 >> cnt_after);

    always_comb
    begin
        mode_next    = mode_reg;
        held_next    = held_reg;
        group_next   = group_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        stopped_next = stopped_reg;
        push         = 1'b0;
        push_job     = '0;
        priority if (cfg_valid)
        begin
            mode_next    = codec_mode;
            held_next    = '0;
            group_next   = '0;
            acc_next     = '0;
            cnt_next     = '0;
            stopped_next = 1'b0;
        end
        else if (accept && !mode_reg)
        begin
            if (n != 2'd3 && !in_last)
            begin
                held_next  = {held_reg[7:0], in_byte};
                group_next = n;
            end
            else
            begin
                push             = 1'b1;
                push_job.enc     = 1'b1;
                push_job.nchar   = {1'b0, n} + 3'd1;
                push_job.has_end = in_last;
                unique case (n)
                    2'd1:    push_job.data = {in_byte, 16'h0000};
                    2'd2:    push_job.data = {held_reg[7:0], in_byte, 8'h00};
                    default: push_job.data = {held_reg, in_byte};
                endcase
                held_next  = '0;
                group_next = '0;
            end
        end
        else if (accept && mode_reg)
        begin
            if (!stopped_reg)
            begin
                if (!dv.ok)
                    stopped_next = 1'b1;
                else
                begin
                    acc_next = acc12[5:0];
                    cnt_next = cnt_after[2:0];
                end
            end
            push_job.enc      = 1'b0;
            push_job.has_byte = !stopped_reg && dv.ok && dec_has;
            push_job.data     = {16'h0000, dec_byte};
            push_job.has_end  = in_last;
            push              = push_job.has_byte || in_last;
            if (in_last)
            begin
                acc_next     = '0;
                cnt_next     = '0;
                stopped_next = 1'b0;
            end
        end
        else
        begin
            // idle cycle: state holds
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            held_reg    <= '0;
            group_reg   <= '0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            held_reg    <= held_next;
            group_reg   <= group_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

/* hw/rtl/b64c_queue.sv */
// Small job FIFO between codec front and back end.
// Depends on b64c_pkg for the job type.
module b64c_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64c_pkg::job_t     push_job,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output b64c_pkg::job_t     head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    b64c_pkg::job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full       = count_reg == CNT_FULL;
    assign head_valid = count_reg != '0;
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job queue written while full");
`endif

endmodule

/* hw/rtl/b64c_back.sv */
// Codec back end: turns a job into result words in an output register, one per unstalled cycle.
// Depends on b64c_pkg.
module b64c_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  b64c_pkg::job_t     q_job,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [7:0]         out_byte,
    output logic               out_valid,
    output logic               run_last,
    output logic               msg_end
);

    b64c_pkg::job_t job_reg;
    logic           job_valid_reg, job_valid_next;
    logic [1:0]     step_reg,      step_next;
    logic           ov_reg,        ov_next;
    logic [7:0]     byte_reg;
    logic           oval_reg;
    logic           rl_reg;
    logic           me_reg;

    logic       load;
    logic       job_done;
    logic [5:0] sextet;
    logic [7:0] r_byte;
    logic       r_valid;
    logic       r_me;

    always_comb
    begin
        unique case (step_reg)
            2'd0:    sextet = job_reg.data[23:18];
            2'd1:    sextet = job_reg.data[17:12];
            2'd2:    sextet = job_reg.data[11:6];
            default: sextet = job_reg.data[5:0];
        endcase
        if (job_reg.enc)
        begin
            r_byte   = ({1'b0, step_reg} < job_reg.nchar) ? b64c_pkg::char_of(sextet)
                                                          : b64c_pkg::PAD_CHAR;
            r_valid  = 1'b1;
            job_done = step_reg == b64c_pkg::ENC_STEP_LAST;
            r_me     = job_done && job_reg.has_end;
        end
        else if (step_reg == b64c_pkg::DEC_STEP_BYTE)
        begin
            r_byte   = job_reg.data[7:0];
            r_valid  = 1'b1;
            job_done = !job_reg.has_end;
            r_me     = 1'b0;
        end
        else
        begin
            r_byte   = 8'h00;   // bare end marker
            r_valid  = 1'b0;
            job_done = 1'b1;
            r_me     = 1'b1;
        end
    end

    assign load = job_valid_reg && (!ov_reg || res_ready);
    assign pop  = q_valid && (!job_valid_reg || (load && job_done));

    always_comb
    begin
        job_valid_next = job_valid_reg;
        step_next      = step_reg;
        ov_next        = ov_reg;
        if (load)
        begin
            ov_next   = 1'b1;
            step_next = step_reg + 2'd1;
            if (job_done)
                job_valid_next = 1'b0;
        end
        else if (ov_reg && res_ready)
            ov_next = 1'b0;
        if (pop)
        begin
            job_valid_next = 1'b1;
            step_next      = (!q_job.enc && !q_job.has_byte) ? b64c_pkg::DEC_STEP_END
                                                             : b64c_pkg::DEC_STEP_BYTE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            step_reg      <= step_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= q_job;
        if (load)
        begin
            byte_reg <= r_byte;
            oval_reg <= r_valid;
            rl_reg   <= job_done;
            me_reg   <= r_me;
        end
    end

    assign res_valid = ov_reg;
    assign out_byte  = byte_reg;
    assign out_valid = oval_reg;
    assign run_last  = rl_reg;
    assign msg_end   = me_reg;

`ifndef SYNTHESIS
    a_dec_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && !job_reg.enc) |->
            (step_reg == b64c_pkg::DEC_STEP_BYTE || step_reg == b64c_pkg::DEC_STEP_END))
        else $error("decode job stepped past its end marker");
`endif

endmodule

/* hw/rtl/base64_stream_codec_unit.sv */
// Base64 stream codec top level: front end, job queue and back end.
// Depends on b64c_pkg, b64c_front, b64c_queue, b64c_back.
//
//  channel | valid     | ready     | word carried
//  --------+-----------+-----------+--------------------------------------------
//  in      | in_valid  | in_ready  | in_byte, in_last
//  cfg     | cfg_valid | cfg_ready | codec_mode (0 encode, 1 decode)
//  result  | res_valid | res_ready | out_byte, out_valid, run_last, msg_end
//
//  Input words are taken one per cycle while the job queue has room and no cfg write
//  is offered; the front end updates message state the same cycle and queues a job
//  for any word with results. The back end puts one result word per cycle into the
//  output register while res_ready keeps up; encode yields four result words per group
//  of up to three input words, decode at most one per word (two for the word that ends
//  a message with a pending byte).
//  Reset clears mode (encode), message state, queue and res_valid; no clearing pass.
//  A stalled result side backs up into the queue and then drops in_ready.
//  A cfg write clears message state; cfg_ready is always high, and in_ready is low
//  in a cycle where a cfg write is offered.
module base64_stream_codec_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       codec_mode,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       run_last,
    output logic       msg_end
);

    // front -> queue
    logic               push;
    b64c_pkg::job_t     push_job;
    logic               q_full;
    // queue -> back
    logic               pop;
    logic               q_valid;
    b64c_pkg::job_t     q_job;

    b64c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .codec_mode(codec_mode),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    b64c_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .head_valid(q_valid),
        .head_job  (q_job)
    );

    b64c_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .run_last  (run_last),
        .msg_end   (msg_end)
    );

`ifndef SYNTHESIS
    // message end always closes the current run of results
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && msg_end) |-> run_last)
        else $error("msg_end without run_last");

    // a bare marker only ever appears as the end of a message, with a zero byte
    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_valid) |-> (msg_end && run_last && out_byte == 8'h00))
        else $error("malformed end marker");
`endif

endmodule
